### hw/rtl/utf8_to_utf16_decoder_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
// Depends on nothing; each user module must have clk and rst in scope.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define U2U_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define U2U_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/u2u_pkg.sv
// Shared types, constants and the lead byte classifier of the UTF-8 decoder.
// Depends on nothing; used by every module of the decoder.
package u2u_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] QMARK     = 16'h003F;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_BASE   = 16'hD800;
  localparam logic [15:0] LO_BASE   = 16'hDC00;

  // One run of bytes that decodes on its own: a complete sequence, a single
  // byte, or the bytes left over at the end of a string.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            fin;
  } run_t;

  // Number of continuation bytes a lead byte asks for, 0 for a non-lead.
  function automatic logic [1:0] lead_len(input logic [7:0] c);
    logic [1:0] n;
    n = 2'd0;
    if ((c & 8'hE0) == 8'hC0) n = 2'd1;
    else if ((c & 8'hF0) == 8'hE0) n = 2'd2;
    else if ((c & 8'hF8) == 8'hF0) n = 2'd3;
    return n;
  endfunction

endpackage

### hw/rtl/u2u_front.sv
// Front end: accepts bytes, gathers open sequences and emits runs.
// Depends on u2u_pkg and the assertion header.
`include "utf8_to_utf16_decoder_defines.svh"

module u2u_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  input  logic          q_full,
  output logic          q_push,
  output u2u_pkg::run_t q_run
);
  import u2u_pkg::*;

  logic [7:0] held [3];
  logic [1:0] held_cnt;
  logic [1:0] need;
  logic [1:0] lead;
  logic       accept;
  logic       start;
  logic       extend;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign lead     = lead_len(s_tdata);
  assign start    = (held_cnt == 2'd0) && (lead != 2'd0) && !s_tlast;
  assign extend   = (held_cnt != 2'd0) && (held_cnt < need) && !s_tlast;
  assign q_push   = accept && !start && !extend;

  always_comb begin
    q_run.bytes = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < held_cnt) q_run.bytes[k] = held[k];
    end
    q_run.bytes[held_cnt] = s_tdata;
    q_run.len = {1'b0, held_cnt} + 3'd1;
    q_run.fin = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (accept && (start || extend)) held[held_cnt] <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt <= 2'd0;
      need     <= 2'd0;
    end else if (accept) begin
      if (start) begin
        held_cnt <= 2'd1;
        need     <= lead;
      end else if (extend) begin
        held_cnt <= held_cnt + 2'd1;
      end else begin
        held_cnt <= 2'd0;
        need     <= 2'd0;
      end
    end
  end

  `U2U_ASSERT(a_open_consistent, ((held_cnt == 2'd0) == (need == 2'd0)) && (held_cnt <= need), "held count and needed count disagree")

endmodule

### hw/rtl/u2u_fifo.sv
// Short queue of byte runs between the front end and the back end.
// Depends on u2u_pkg and the assertion header.
`include "utf8_to_utf16_decoder_defines.svh"

module u2u_fifo #(
  parameter int DEPTH = u2u_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u2u_pkg::run_t push_run,
  output logic          full,
  input  logic          pop,
  output u2u_pkg::run_t head_run,
  output logic          empty
);
  import u2u_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_run = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  `U2U_ASSERT(a_no_overflow, !(push && full), "run pushed into a full queue")
  `U2U_ASSERT(a_no_underflow, !(pop && empty), "run popped from an empty queue")
  `U2U_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

### hw/rtl/u2u_back.sv
// Back end: decodes one queued run into UTF-16 code units, one per cycle while the output is not stalled.
// Depends on u2u_pkg and the assertion header.
`include "utf8_to_utf16_decoder_defines.svh"

module u2u_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_pop,
  input  u2u_pkg::run_t q_run,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tlast,
  output logic          m_tuser
);
  import u2u_pkg::*;

  run_t        run;
  logic        active;
  logic [1:0]  pos;
  logic        half;

  logic [7:0]  c, b1, b2, b3;
  logic [1:0]  need;
  logic [2:0]  rem;
  logic [2:0]  step;
  logic [2:0]  pos_sum;
  logic [20:0] cp;
  logic [20:0] v;
  logic        big;
  logic [15:0] unit;
  logic        unit_last;
  logic        take;

  always_comb begin
    c    = run.bytes[pos];
    b1   = run.bytes[pos + 2'd1];
    b2   = run.bytes[pos + 2'd2];
    b3   = run.bytes[pos + 2'd3];
    need = lead_len(c);
    rem  = run.len - {1'b0, pos};
    if (!c[7]) begin
      cp   = {13'd0, c};
      step = 3'd1;
    end else if (need == 2'd1 && rem > 3'd1) begin
      cp   = {10'd0, c[4:0], b1[5:0]};
      step = 3'd2;
    end else if (need == 2'd2 && rem > 3'd2) begin
      cp   = {5'd0, c[3:0], b1[5:0], b2[5:0]};
      step = 3'd3;
    end else if (need == 2'd3 && rem > 3'd3) begin
      cp   = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
      step = 3'd4;
    end else begin
      cp   = {5'd0, QMARK};
      step = 3'd1;
    end
    big     = (cp[20:16] != 5'd0);
    v       = cp - SUPP_BASE;
    pos_sum = {1'b0, pos} + step;
    if (half)     unit = {6'd0, v[9:0]} + LO_BASE;
    else if (big) unit = {5'd0, v[20:10]} + HI_BASE;
    else          unit = cp[15:0];
    unit_last = (half || !big) && (pos_sum == run.len);
  end

  assign take  = active && (!m_tvalid || m_tready);
  assign q_pop = !q_empty && (!active || (take && unit_last));

  always_ff @(posedge clk) begin
    if (q_pop) run <= q_run;
    if (take) begin
      m_tdata <= unit;
      m_tlast <= unit_last;
      m_tuser <= unit_last && run.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pos      <= 2'd0;
      half     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (q_pop) begin
        active <= 1'b1;
        pos    <= 2'd0;
        half   <= 1'b0;
      end else if (take) begin
        if (unit_last) begin
          active <= 1'b0;
          half   <= 1'b0;
        end else if (!half && big) begin
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          pos  <= pos_sum[1:0];
        end
      end
    end
  end

  `U2U_ASSERT(a_half_needs_run, half |-> active, "low surrogate pending without a run")

endmodule

### hw/rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder: one byte per transfer in, one code unit per transfer out.
// Runs pass the queue and the back end's run register; code units leave from an output register.
// Throughput, when not stalled: one byte per cycle in and one code unit per cycle out; a run that
// yields several units (surrogate pairs, replay at string end) uses one output cycle per unit.
// Reset: synchronous, active high; it drops any open sequence, empties the queue and
// clears the output valid flag.
`include "utf8_to_utf16_decoder_defines.svh"

module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: one UTF-8 byte per transfer.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // final_byte
  // Output stream: one UTF-16 code unit per transfer.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // [0] end_of_string
);
  import u2u_pkg::*;

  // The front end gathers bytes of an open sequence and hands every byte run
  // that is ready to decode (a finished sequence, a lone byte, or the held
  // bytes plus the final byte of a string) to the queue. It never stalls on
  // the output side except when the queue is full.
  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  run_t push_run;
  run_t head_run;

  u2u_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_run    (push_run)
  );

  // The queue lets the back end work through a multi-unit run while the
  // front end keeps taking bytes.
  u2u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (q_pop),
    .head_run (head_run),
    .empty    (q_empty)
  );

  // The back end walks one run, producing one code unit per cycle into its output register while the
  // output is not stalled, and pops the next run in the cycle it registers the last unit of a run.
  u2u_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_run    (head_run),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // The end of a string always closes a run, so it never comes without last_of_run.
  `U2U_ASSERT(a_eos_is_last, (m_tvalid && m_tuser) |-> m_tlast, "end of string without last of run")

endmodule
